### hdl/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// shared types and constants of the datagram sequence reassembler
// ----------------------------------------------------------------------------
package dsr_pkg;

	localparam int SEQ_W = 31;
	localparam int LEN_W = 15;
	localparam int CAP_W = 18;
	localparam int VERDICT_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 18'd16384;

	// verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_WHOLE    = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_STALE    = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_GAP      = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_ILLEGAL  = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_STORED   = 3'd4;
	localparam logic [VERDICT_W-1:0] VERDICT_TOO_BIG  = 3'd5;
	localparam logic [VERDICT_W-1:0] VERDICT_COMPLETE = 3'd6;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [SEQ_W-1:0]     dropped_count;
		logic [LEN_W-1:0]     copy_offset;
		logic [LEN_W-1:0]     copy_length;
		logic [LEN_W-1:0]     assembled_length;
		logic [SEQ_W-1:0]     current_sequence;
	} result_t;

endpackage

### hdl/dsr_front.sv
// ----------------------------------------------------------------------------
// dsr_front
// classifies each header against the channel state and updates that state
// ----------------------------------------------------------------------------
module dsr_front #(
	parameter int FRAGMENT_BYTES = 1300,
	parameter int BUFFER_BYTES   = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dsr_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                        take,
	input  logic [dsr_pkg::SEQ_W-1:0]   seq_number,
	input  logic                        is_fragment,
	input  logic signed [31:0]          frag_offset,
	input  logic signed [15:0]          frag_bytes,
	input  logic [15:0]                 payload_available,
	output dsr_pkg::result_t            result
);

	localparam int ASM_W = $clog2(BUFFER_BYTES + 1);
	localparam int SUM_W = ((ASM_W > 15) ? ASM_W : 15) + 1;
	localparam int CMP_W = (SUM_W > dsr_pkg::CAP_W) ? SUM_W : dsr_pkg::CAP_W;

	logic [dsr_pkg::CAP_W-1:0] capacity_q;
	logic [dsr_pkg::SEQ_W-1:0] incoming_q;
	logic [dsr_pkg::SEQ_W-1:0] dropped_q;
	logic [dsr_pkg::SEQ_W-1:0] run_seq_q;
	logic [ASM_W-1:0]          assembled_q;

	logic                      stale;
	logic [dsr_pkg::SEQ_W-1:0] dropped_new;
	logic                      new_run;
	logic [ASM_W-1:0]          asm_eff;
	logic [31:0]               asm_ext;
	logic                      gap;
	logic                      illegal;
	logic [SUM_W-1:0]          sum;
	logic [31:0]               sum_ext;
	logic                      full_frag;
	logic                      over_cap;

	assign stale       = (seq_number <= incoming_q);
	assign dropped_new = seq_number - incoming_q - dsr_pkg::SEQ_W'(1);
	assign new_run     = (seq_number != run_seq_q);
	assign asm_eff     = new_run ? '0 : assembled_q;
	assign asm_ext     = 32'(asm_eff);
	assign gap         = (asm_ext != frag_offset);
	assign sum         = SUM_W'(asm_eff) + SUM_W'(frag_bytes[14:0]);
	assign sum_ext     = 32'(sum);
	assign illegal     = frag_bytes[15]
		|| (frag_bytes > $signed({1'b0, payload_available}))
		|| (sum > SUM_W'(BUFFER_BYTES));
	assign full_frag   = (frag_bytes == 16'(FRAGMENT_BYTES));
	assign over_cap    = (CMP_W'(sum) > CMP_W'(capacity_q));

	always_comb begin
		result                  = '0;
		result.dropped_count    = dropped_q;
		result.current_sequence = incoming_q;
		if (stale) begin
			result.verdict = dsr_pkg::VERDICT_STALE;
		end else begin
			result.dropped_count = dropped_new;
			if (!is_fragment) begin
				result.verdict          = dsr_pkg::VERDICT_WHOLE;
				result.current_sequence = seq_number;
			end else if (gap) begin
				result.verdict = dsr_pkg::VERDICT_GAP;
			end else if (illegal) begin
				result.verdict = dsr_pkg::VERDICT_ILLEGAL;
			end else begin
				result.copy_offset = asm_ext[dsr_pkg::LEN_W-1:0];
				result.copy_length = frag_bytes[dsr_pkg::LEN_W-1:0];
				if (full_frag) begin
					result.verdict = dsr_pkg::VERDICT_STORED;
				end else if (over_cap) begin
					result.verdict = dsr_pkg::VERDICT_TOO_BIG;
				end else begin
					result.verdict          = dsr_pkg::VERDICT_COMPLETE;
					result.assembled_length = sum_ext[dsr_pkg::LEN_W-1:0];
					result.current_sequence = seq_number;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= dsr_pkg::CAP_RESET;
			incoming_q  <= '0;
			dropped_q   <= '0;
			run_seq_q   <= '0;
			assembled_q <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (take && !stale) begin
				dropped_q <= dropped_new;
				if (!is_fragment) begin
					incoming_q <= seq_number;
				end else begin
					run_seq_q <= seq_number;
					if (gap || illegal) begin
						assembled_q <= asm_eff;
					end else if (full_frag || over_cap) begin
						assembled_q <= ASM_W'(sum);
					end else begin
						assembled_q <= '0;
						incoming_q  <= seq_number;
					end
				end
			end
		end
	end

endmodule

### hdl/dsr_queue.sv
// ----------------------------------------------------------------------------
// dsr_queue
// two-entry result queue between the classifier and the output stage
// ----------------------------------------------------------------------------
module dsr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dsr_pkg::result_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output dsr_pkg::result_t pop_data
);

	dsr_pkg::result_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/dsr_back.sv
// ----------------------------------------------------------------------------
// dsr_back
// output register stage, refilled from the queue whenever it empties or moves
// ----------------------------------------------------------------------------
module dsr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  dsr_pkg::result_t q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output dsr_pkg::result_t out_data
);

	logic             valid_q;
	dsr_pkg::result_t data_q;

	assign q_pop     = q_not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

### hdl/datagram_sequence_reassembler.sv
// ----------------------------------------------------------------------------
// datagram_sequence_reassembler
// receive-side sequence checker and fragment reassembly bookkeeping
// result path: a transferred header's result is written to the queue, then loaded
//   into the output register, which drives m_tvalid
// throughput: one header per cycle; s_tready drops only when the two-entry
//   queue is full, i.e. when the output side has stalled
// reset: arst_n clears the sequence state and the queue, capacity to 16384
// ----------------------------------------------------------------------------
module datagram_sequence_reassembler #(
	parameter int FRAGMENT_BYTES = 1300,
	parameter int BUFFER_BYTES   = 16384
) (
	input  logic         clk,
	input  logic         arst_n,
	// capacity register write
	input  logic         cfg_we,
	input  logic [17:0]  cfg_wdata,
	// header stream in
	input  logic         s_tvalid,
	output logic         s_tready,
	// seq_number[30:0], frag_offset[62:31], frag_bytes[78:63],
	// payload_available[94:79], zero pad[95]
	input  logic [95:0]  s_tdata,
	// is_fragment[0]
	input  logic         s_tuser,
	// verdict stream out
	output logic         m_tvalid,
	input  logic         m_tready,
	// dropped_count[30:0], copy_offset[45:31], copy_length[60:46],
	// assembled_length[75:61], current_sequence[106:76], zero pad[111:107]
	output logic [111:0] m_tdata,
	// verdict[2:0]
	output logic [2:0]   m_tuser
);

	logic             q_full;
	logic             take;
	dsr_pkg::result_t front_res;
	logic             q_pop;
	logic             q_not_empty;
	dsr_pkg::result_t q_data;
	dsr_pkg::result_t out_res;

	// a transfer is taken while the queue has room
	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	// front: compares against the channel state and updates it in the same cycle
	dsr_front #(
		.FRAGMENT_BYTES (FRAGMENT_BYTES),
		.BUFFER_BYTES   (BUFFER_BYTES)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.take              (take),
		.seq_number        (s_tdata[30:0]),
		.is_fragment       (s_tuser),
		.frag_offset       (s_tdata[62:31]),
		.frag_bytes        (s_tdata[78:63]),
		.payload_available (s_tdata[94:79]),
		.result            (front_res)
	);

	// queue decouples classification from the output handshake
	dsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (front_res),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	// back: registered master side
	dsr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (out_res)
	);

	assign m_tuser = out_res.verdict;
	assign m_tdata = {5'd0, out_res.current_sequence, out_res.assembled_length,
		out_res.copy_length, out_res.copy_offset, out_res.dropped_count};

endmodule
